>>> rtl/pid_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and fixed-point helpers for the pid controller
package pid_pkg;

    localparam int          FRAC_BITS_DEF = 16;
    // pi with 30 fractional bits, rounded to nearest in the working format by the users
    localparam logic [63:0] PI_Q30        = 64'd3373259426;

    typedef enum logic [2:0] {
        REG_KP          = 3'd0,
        REG_KI_HALF     = 3'd1,
        REG_KD_COEF     = 3'd2,
        REG_FILTER_COEF = 3'd3,
        REG_MAX_OUT     = 3'd4,
        REG_ANGLE_MODE  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic en;
        logic angle;
    } t_wrap_ctl;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // exact product, floor shift, saturate
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input int unsigned fb);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat32(p >>> fb);
    endfunction

endpackage

>>> rtl/pid_wrap.sv
`timescale 1ns / 1ps
// four-stage difference unit: saturating subtract or wrap into [-pi, pi]
module pid_wrap #(
    parameter int FRAC_BITS = pid_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  pid_pkg::t_wrap_ctl   i_ctl,
    input  logic signed [31:0]   i_a,
    input  logic signed [31:0]   i_b,
    output logic signed [31:0]   o_diff
);

    localparam logic [33:0] PI_Q     =
        34'((pid_pkg::PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    localparam logic [33:0] TWO_PI_Q = 34'(PI_Q << 1);
    localparam logic [63:0] RECIP    = (64'd1 << 33) / 64'(TWO_PI_Q);
    localparam int          QW       = $clog2(RECIP + 64'd1);

    // stage 1
    logic signed [32:0]  r_d;
    logic                r_ang;
    // stage 2
    logic [32:0]         r_n2;
    logic                r_pos2;
    logic                r_neg2;
    logic signed [31:0]  r_sat2;
    // stage 3
    logic [QW-1:0]       r_q3;
    logic [32:0]         r_n3;
    logic                r_pos3;
    logic                r_neg3;
    logic signed [31:0]  r_sat3;

    logic signed [33:0]  w_d34;
    logic signed [33:0]  w_pi_s;
    logic                w_pos;
    logic                w_neg;
    logic signed [33:0]  w_mag;
    logic signed [33:0]  w_n;
    logic [63:0]         w_prod;
    logic [33:0]         w_qt;
    logic [33:0]         w_rem;
    logic [33:0]         w_red;
    logic signed [33:0]  w_x;
    logic signed [31:0]  w_out;

    always_comb begin
        w_d34  = 34'(r_d);
        w_pi_s = signed'(PI_Q);
        w_pos  = w_d34 > w_pi_s;
        w_neg  = w_d34 < -w_pi_s;
        w_mag  = w_pos ? w_d34 : -w_d34;
        // distance past the limit, minus one, so that the step count is quotient plus one
        w_n    = w_mag - w_pi_s - 34'sd1;
    end

    assign w_prod = 64'(r_n2) * RECIP;

    always_comb begin
        // quotient estimate may be one low, the remainder compare fixes it
        w_qt  = 34'(r_q3) * TWO_PI_Q;
        w_rem = {1'b0, r_n3} - w_qt;
        w_red = (w_rem >= TWO_PI_Q) ? (w_rem - TWO_PI_Q) : w_rem;
        if (r_pos3) begin
            w_x = signed'(w_red) + 34'sd1 - w_pi_s;
        end else begin
            w_x = w_pi_s - 34'sd1 - signed'(w_red);
        end
        if (r_pos3 || r_neg3) begin
            w_out = w_x[31:0];
        end else begin
            w_out = r_sat3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_d    <= 33'(i_a) - 33'(i_b);
            r_ang  <= i_ctl.angle;

            r_n2   <= w_n[32:0];
            r_pos2 <= r_ang && w_pos;
            r_neg2 <= r_ang && w_neg;
            r_sat2 <= pid_pkg::sat32(64'(r_d));

            r_q3   <= w_prod[33 +: QW];
            r_n3   <= r_n2;
            r_pos3 <= r_pos2;
            r_neg3 <= r_neg2;
            r_sat3 <= r_sat2;

            o_diff <= w_out;
        end
    end

endmodule

>>> rtl/pid_controller_step.sv
`timescale 1ns / 1ps
// pid controller with filtered derivative, signed fixed point, apb register port
// throughput: one item per cycle while the receiver keeps taking results; i_ready low stalls it
// the rate is set by the integrator and derivative filter updates, each closed in
// one stage (filter multiply plus saturating add feeding back into itself)
// reset (synchronous, active low) clears the pipeline valid bits, controller state and registers;
// max_out comes up at 1.0
module pid_controller_step #(
    parameter int FRAC_BITS = pid_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // sample channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [31:0]  i_setpoint,
    input  logic signed [31:0]  i_measurement,
    // drive channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [31:0]  o_drive,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // pipeline stage positions
    localparam int unsigned NSTG    = 9;
    localparam int unsigned ST_WRAP = 4;   // wrap unit output
    localparam int unsigned ST_PROD = 6;   // gain products
    localparam int unsigned ST_OUT  = 8;   // result register

    localparam logic [30:0] LIM_RECIP = 31'((64'd1 << 33) / 5);

    // configuration registers
    logic signed [31:0] r_kp;
    logic signed [31:0] r_ki_half;
    logic signed [31:0] r_kd_coef;
    logic signed [31:0] r_filter_coef;
    logic [30:0]        r_max_out;
    logic               r_angle_mode;

    // integrator limit, 4/5 of max_out via reciprocal multiply
    logic [32:0]        r_lim_v;
    logic [30:0]        r_lim_q;
    logic [30:0]        r_lim;

    // controller state
    logic signed [31:0] r_last_meas;
    logic signed [31:0] r_last_err;
    logic signed [31:0] r_int;
    logic signed [31:0] r_der;

    // pipeline
    logic [NSTG-1:0]    r_vld;
    logic signed [31:0] r_sp;
    logic signed [31:0] r_meas;
    logic signed [31:0] r_pm;
    logic signed [31:0] r_err5;
    logic signed [31:0] r_diff5;
    logic signed [31:0] r_esum5;
    logic signed [31:0] r_pp;
    logic signed [31:0] r_pi;
    logic signed [31:0] r_pd;
    logic signed [31:0] r_p7;
    logic signed [31:0] r_drive;

    logic               w_adv;
    logic               w_accept;
    logic               w_cfg_wr;
    pid_pkg::t_reg_idx  w_idx;
    pid_pkg::t_wrap_ctl w_wctl;
    logic signed [31:0] w_err;
    logic signed [31:0] w_diff;
    logic signed [31:0] w_esum;
    logic [32:0]        w_lim_v;
    logic [63:0]        w_lim_prod;
    logic [33:0]        w_lim_rem;
    logic signed [33:0] w_lim_s;
    logic signed [31:0] w_int_sum;
    logic signed [31:0] w_int_next;
    logic signed [31:0] w_fc_prod;
    logic signed [31:0] w_dsum;
    logic signed [31:0] w_der_next;
    logic signed [33:0] w_out_sum;
    logic signed [33:0] w_mo_s;
    logic signed [31:0] w_out_clamp;

    // whole pipeline moves together; an empty result register or a ready receiver lets it move
    assign w_adv    = !r_vld[ST_OUT] || i_ready;
    assign o_ready  = w_adv;
    assign w_accept = i_valid && w_adv;
    assign o_valid  = r_vld[ST_OUT];
    assign o_drive  = r_drive;

    // register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_idx    = pid_pkg::t_reg_idx'(paddr[4:2]);

    always_comb begin
        unique case (w_idx)
            pid_pkg::REG_KP:          prdata = r_kp;
            pid_pkg::REG_KI_HALF:     prdata = r_ki_half;
            pid_pkg::REG_KD_COEF:     prdata = r_kd_coef;
            pid_pkg::REG_FILTER_COEF: prdata = r_filter_coef;
            pid_pkg::REG_MAX_OUT:     prdata = {1'b0, r_max_out};
            pid_pkg::REG_ANGLE_MODE:  prdata = {31'd0, r_angle_mode};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp          <= '0;
            r_ki_half     <= '0;
            r_kd_coef     <= '0;
            r_filter_coef <= '0;
            r_max_out     <= 31'd65536;
            r_angle_mode  <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                pid_pkg::REG_KP:          r_kp          <= pwdata;
                pid_pkg::REG_KI_HALF:     r_ki_half     <= pwdata;
                pid_pkg::REG_KD_COEF:     r_kd_coef     <= pwdata;
                pid_pkg::REG_FILTER_COEF: r_filter_coef <= pwdata;
                pid_pkg::REG_MAX_OUT:     r_max_out     <= pwdata[30:0];
                pid_pkg::REG_ANGLE_MODE:  r_angle_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // integrator limit: quotient estimate then one remainder correction
    assign w_lim_v    = {r_max_out, 2'b00};
    assign w_lim_prod = 64'(w_lim_v) * 64'(LIM_RECIP);
    assign w_lim_rem  = 34'(r_lim_v) - (34'(r_lim_q) << 2) - 34'(r_lim_q);

    always_ff @(posedge i_clk) begin
        r_lim_v <= w_lim_v;
        r_lim_q <= w_lim_prod[63:33];
        r_lim   <= r_lim_q + 31'(w_lim_rem >= 34'd5);
    end

    // input register, previous measurement rides along
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sp   <= i_setpoint;
            r_meas <= i_measurement;
            r_pm   <= r_last_meas;
        end
    end

    assign w_wctl.en    = w_adv;
    assign w_wctl.angle = r_angle_mode;

    // error and measurement difference, four stages each
    pid_wrap #(.FRAC_BITS(FRAC_BITS)) u_wrap_err (
        .i_clk  (i_clk),
        .i_ctl  (w_wctl),
        .i_a    (r_sp),
        .i_b    (r_meas),
        .o_diff (w_err)
    );

    pid_wrap #(.FRAC_BITS(FRAC_BITS)) u_wrap_diff (
        .i_clk  (i_clk),
        .i_ctl  (w_wctl),
        .i_a    (r_meas),
        .i_b    (r_pm),
        .o_diff (w_diff)
    );

    // trapezoid sum of this and the previous wrapped error
    assign w_esum = pid_pkg::sat32(64'(w_err) + 64'(r_last_err));

    // integrator and derivative filter recurrences
    always_comb begin
        w_lim_s   = signed'({3'b000, r_lim});
        w_int_sum = pid_pkg::sat32(64'(r_int) + 64'(r_pi));
        if (34'(w_int_sum) > w_lim_s) begin
            w_int_next = w_lim_s[31:0];
        end else if (34'(w_int_sum) < -w_lim_s) begin
            w_int_next = 32'(-w_lim_s);
        end else begin
            w_int_next = w_int_sum;
        end

        w_fc_prod  = pid_pkg::mulq(r_filter_coef, r_der, FRAC_BITS);
        w_dsum     = pid_pkg::sat32(64'(r_pd) + 64'(w_fc_prod));
        w_der_next = pid_pkg::sat32(-64'(w_dsum));
    end

    // output sum and clamp to plus or minus max_out
    always_comb begin
        w_mo_s    = signed'({3'b000, r_max_out});
        w_out_sum = 34'(r_p7) + 34'(r_int) + 34'(r_der);
        if (w_out_sum > w_mo_s) begin
            w_out_clamp = w_mo_s[31:0];
        end else if (w_out_sum < -w_mo_s) begin
            w_out_clamp = 32'(-w_mo_s);
        end else begin
            w_out_clamp = w_out_sum[31:0];
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_err5  <= w_err;
            r_diff5 <= w_diff;
            r_esum5 <= w_esum;

            r_pp    <= pid_pkg::mulq(r_kp, r_err5, FRAC_BITS);
            r_pi    <= pid_pkg::mulq(r_ki_half, r_esum5, FRAC_BITS);
            r_pd    <= pid_pkg::mulq(r_kd_coef, r_diff5, FRAC_BITS);

            r_p7    <= r_pp;
            r_drive <= w_out_clamp;
        end
    end

    // valid bits and controller state; the state is updated only by real items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_last_meas <= '0;
            r_last_err  <= '0;
            r_int       <= '0;
            r_der       <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
            if (w_accept) begin
                r_last_meas <= i_measurement;
            end
            if (r_vld[ST_WRAP]) begin
                r_last_err <= w_err;
            end
            // item in the product stage moves into the state stage
            if (r_vld[ST_PROD]) begin
                r_int <= w_int_next;
                r_der <= w_der_next;
            end
        end
    end

endmodule

>>> rtl/pid_chk.sv
`timescale 1ns / 1ps
// port-level checks for the pid controller, bound to the top level
module pid_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_drive
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_drive))
        else $error("drive item changed while stalled");

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty result register");

    // limit is at most 2^31-1, so the most negative code never appears
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_drive != 32'sh80000000))
        else $error("drive outside clamp range");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind pid_controller_step pid_chk u_pid_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_drive (o_drive)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for pid_controller_step: sample stream in, drive stream out
module tb;

    localparam int     FRAC       = pid_pkg::FRAC_BITS_DEF;
    localparam longint PI_FIX     =
        longint'((pid_pkg::PI_Q30 + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
    localparam longint TWO_PI_FIX = 2 * PI_FIX;
    localparam int     PI_I       = int'(PI_FIX);
    localparam int     CYCLE_LIMIT = 500000;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_setpoint    = '0;
    logic signed [31:0] i_measurement = '0;
    logic               o_valid;
    logic               i_ready       = 1'b0;
    logic signed [31:0] o_drive;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [4:0]         paddr         = '0;
    logic [31:0]        pwdata        = '0;
    logic [31:0]        prdata;
    logic               pready;

    pid_controller_step dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_setpoint    (i_setpoint),
        .i_measurement (i_measurement),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_drive       (o_drive),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // controller registers as the predictor sees them
    longint g_kp, g_ki_half, g_kd_coef, g_filter_coef, g_max_out;
    bit     g_angle;
    // controller state as the predictor sees it
    longint integ_acc, last_err, deriv_acc, last_meas;

    logic signed [31:0] pending_drive[$];
    int  drive_errors  = 0;
    int  cycle_count   = 0;
    int  send_idle_pct = 36;
    int  ready_idle_pct = 36;
    int  hold_cycles   = 0;
    int  plant_pos     = 0;
    int  plant_target  = 0;

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // fixed-point product, floor on the dropped bits
    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clip32(p >>> FRAC);
    endfunction

    function automatic longint wrap_pi(input longint x);
        longint k;
        if (x > PI_FIX) begin
            k = (x - PI_FIX + TWO_PI_FIX - 1) / TWO_PI_FIX;
            x = x - k * TWO_PI_FIX;
        end else if (x < -PI_FIX) begin
            k = (-PI_FIX - x + TWO_PI_FIX - 1) / TWO_PI_FIX;
            x = x + k * TWO_PI_FIX;
        end
        return x;
    endfunction

    function automatic longint angle_or_sat_diff(input longint a, input longint b);
        return g_angle ? wrap_pi(a - b) : clip32(a - b);
    endfunction

    function automatic void pid_model_reset();
        g_kp          = 0;
        g_ki_half     = 0;
        g_kd_coef     = 0;
        g_filter_coef = 0;
        g_max_out     = 65536;
        g_angle       = 1'b0;
        integ_acc     = 0;
        last_err      = 0;
        deriv_acc     = 0;
        last_meas     = 0;
    endfunction

    // advances the controller state by one sample, returns the drive it should produce
    function automatic logic signed [31:0] pid_next_drive(input logic signed [31:0] sp,
                                                          input logic signed [31:0] meas);
        longint err, prop, lim, dmeas, dsum, total;
        err = angle_or_sat_diff(sp, meas);
        prop = qmul(g_kp, err);
        // trapezoidal integrator with anti-windup at 80 percent of the output limit
        integ_acc = clip32(integ_acc + qmul(g_ki_half, clip32(err + last_err)));
        lim = (g_max_out * 4) / 5;
        if (integ_acc > lim) integ_acc = lim;
        if (integ_acc < -lim) integ_acc = -lim;
        // derivative on measurement through the first-order filter
        dmeas = angle_or_sat_diff(meas, last_meas);
        dsum = clip32(qmul(g_kd_coef, dmeas) + qmul(g_filter_coef, deriv_acc));
        deriv_acc = clip32(-dsum);
        total = prop + integ_acc + deriv_acc;
        if (total > g_max_out) total = g_max_out;
        if (total < -g_max_out) total = -g_max_out;
        last_err = err;
        last_meas = meas;
        return total[31:0];
    endfunction

    function automatic void note_mismatch(input string what, input logic signed [31:0] want,
                                          input logic signed [31:0] got);
        drive_errors++;
        if (drive_errors <= 10)
            $display("mismatch %0s at %0t: expected %0d actual %0d", what, $realtime, want, got);
    endfunction

    // both handshakes are seen here, accepted items first so a same-edge result finds them
    always @(posedge i_clk) begin
        logic signed [31:0] want;
        if (i_rst_n && i_valid && o_ready)
            pending_drive.push_back(pid_next_drive(i_setpoint, i_measurement));
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_drive.size() == 0) begin
                note_mismatch("unexpected drive", 'x, o_drive);
            end else begin
                want = pending_drive.pop_front();
                if (o_drive !== want) note_mismatch("drive", want, o_drive);
            end
        end
    end

    // receiver: random stalls, or a counted hold-off when a test asks for one
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= ready_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // all tasks below start and end at a falling edge
    task automatic reg_write(input pid_pkg::t_reg_idx idx, input logic [31:0] val);
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            pid_pkg::REG_KP:          g_kp = $signed(val);
            pid_pkg::REG_KI_HALF:     g_ki_half = $signed(val);
            pid_pkg::REG_KD_COEF:     g_kd_coef = $signed(val);
            pid_pkg::REG_FILTER_COEF: g_filter_coef = $signed(val);
            pid_pkg::REG_MAX_OUT:     g_max_out = longint'(val[30:0]);
            pid_pkg::REG_ANGLE_MODE:  g_angle = val[0];
            default: ;
        endcase
    endtask

    task automatic set_gains(input logic [31:0] kp, input logic [31:0] ki, input logic [31:0] kd,
                             input logic [31:0] fc, input logic [31:0] mo, input bit angle);
        reg_write(pid_pkg::REG_KP, kp);
        reg_write(pid_pkg::REG_KI_HALF, ki);
        reg_write(pid_pkg::REG_KD_COEF, kd);
        reg_write(pid_pkg::REG_FILTER_COEF, fc);
        reg_write(pid_pkg::REG_MAX_OUT, mo);
        reg_write(pid_pkg::REG_ANGLE_MODE, {31'd0, angle});
    endtask

    task automatic send_sample(input logic signed [31:0] sp, input logic signed [31:0] meas);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid       <= 1'b1;
        i_setpoint    <= sp;
        i_measurement <= meas;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every drive has come back
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_drive.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] corner_value();
        case ($urandom_range(8))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            3: return -1;
            4: return 1;
            5: return PI_I;
            6: return -PI_I;
            7: return PI_I + 1;
            default: return -PI_I - 1;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_gain();
        if ($urandom_range(3) == 0) return $urandom();
        return int'($urandom_range(0, 524288)) - 262144;
    endfunction

    function automatic logic [31:0] rand_limit();
        case ($urandom_range(5))
            0:       return $urandom_range(32'h7fffffff);
            1:       return $urandom_range(3);
            default: return $urandom_range(1, 1310720);
        endcase
    endfunction

    task automatic send_random(input int count);
        logic signed [31:0] sp, meas;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0, 1: begin
                    sp   = $urandom();
                    meas = $urandom();
                end
                2, 3: begin
                    sp   = int'($urandom_range(0, 8 * PI_I)) - 4 * PI_I;
                    meas = int'($urandom_range(0, 8 * PI_I)) - 4 * PI_I;
                end
                4: begin
                    sp   = corner_value();
                    meas = ($urandom_range(1) != 0) ? corner_value() : $urandom();
                end
                default: begin
                    // a slowly moving plant that chases a step setpoint
                    if ($urandom_range(15) == 0)
                        plant_target = int'($urandom_range(0, 1310720)) - 655360;
                    plant_pos = plant_pos + ((plant_target - plant_pos) >>> 3)
                                + int'($urandom_range(0, 8192)) - 4096;
                    sp   = plant_target;
                    meas = plant_pos;
                end
            endcase
            send_sample(sp, meas);
        end
    endtask

    // registers straight out of reset: every drive must be zero
    task automatic test_reset_values();
        send_sample(32'sd65536, 32'sd0);
        send_sample(32'sh7fffffff, 32'sh80000000);
        send_sample(-32'sd1, 32'sd12345);
        settle();
    endtask

    task automatic test_directed_edges();
        // plain mode: saturating error and difference at the field extremes
        set_gains(32'd65536, 32'd32768, 32'd131072, 32'd32768, 32'h7fffffff, 1'b0);
        send_sample(32'sd0, 32'sd0);
        send_sample(32'sh7fffffff, 32'sh80000000);
        send_sample(32'sh80000000, 32'sh7fffffff);
        send_sample(32'sh7fffffff, 32'sh7fffffff);
        send_sample(32'sh80000000, 32'sh80000000);
        send_sample(-32'sd1, 32'sd0);
        settle();
        // angle mode: errors on and just past +-pi, a turn out, and the widest span
        set_gains(32'd65536, 32'd65536, 32'd65536, 32'd0, 32'h7fffffff, 1'b1);
        send_sample(PI_I, 32'sd0);
        send_sample(PI_I + 1, 32'sd0);
        send_sample(-PI_I, 32'sd0);
        send_sample(-PI_I - 1, 32'sd0);
        send_sample(3 * PI_I + 1, 32'sd0);
        send_sample(32'sh7fffffff, 32'sh80000000);
        send_sample(32'sh80000000, 32'sh7fffffff);
        send_sample(32'sd0, -PI_I - 1);
        settle();
        // zero limit forces integrator and drive to zero
        set_gains(32'd65536, 32'd65536, 32'd65536, 32'd65536, 32'd0, 1'b0);
        send_sample(32'sd1000000, 32'sd0);
        send_sample(32'sd0, 32'sd1000000);
        settle();
        // gain extremes with the smallest nonzero limit
        set_gains(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'd1, 1'b0);
        send_sample(32'sd1, 32'sd0);
        send_sample(32'sh7fffffff, 32'sd0);
        send_sample(32'sd0, 32'sh80000000);
        settle();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 4)
                set_gains(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                          32'h7fffffff, 1'b0);
            else
                set_gains(rand_gain(), rand_gain(),
                          rand_gain(), int'($urandom_range(0, 131072)) - 65536,
                          rand_limit(), ph[0]);
            send_random(250);
            settle();
        end
    endtask

    // long receiver hold-off while samples keep coming, so the input side has to stall
    task automatic test_backpressure();
        set_gains(rand_gain(), rand_gain(), rand_gain(), 32'd49152, 32'd655360, 1'b0);
        send_idle_pct = 0;
        hold_cycles = 300;
        send_random(120);
        send_idle_pct = 36;
        settle();
    endtask

    // back-to-back items with no stalls on either side
    task automatic test_full_rate();
        set_gains(rand_gain(), rand_gain(), rand_gain(), 32'hffff0000, rand_limit(), 1'b1);
        send_idle_pct = 0;
        ready_idle_pct = 0;
        send_random(200);
        send_idle_pct = 36;
        ready_idle_pct = 36;
        settle();
    endtask

    initial begin
        pid_model_reset();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_directed_edges();
        test_random_phases();
        test_backpressure();
        test_full_rate();
        repeat (20) @(posedge i_clk);
        if (drive_errors == 0 && pending_drive.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/pid_pkg.sv
rtl/pid_wrap.sv
rtl/pid_controller_step.sv
rtl/pid_chk.sv
tb/sv/tb.sv
